// ===== rtl/nmea_rmc_position_parser_macros.svh =====
// Assertion macros used by the RMC position parser top module.
// No dependencies; the macros expand to nothing when SYNTHESIS is defined.
`ifndef NMEA_RMC_POSITION_PARSER_MACROS_SVH
`define NMEA_RMC_POSITION_PARSER_MACROS_SVH
`ifndef SYNTHESIS
`define NRMC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nrmc: same-cycle check failed");
`define NRMC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nrmc: next-cycle check failed");
`else
`define NRMC_ASSERT_IMP(label, clk, rst, ante, cons)
`define NRMC_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/nrmc_pkg.sv =====
// Types and constants shared by the RMC position parser modules.
// No dependencies.
package nrmc_pkg;

   localparam int DEG_W = 10;
   localparam int MM_W  = 7;
   localparam int HDG_W = 17;
   localparam int MAG_W = 34;

   localparam logic [MAG_W-1:0] E7 = 34'd10000000;

   localparam logic [23:0] POW10 [8] = '{
      24'd1, 24'd10, 24'd100, 24'd1000, 24'd10000, 24'd100000, 24'd1000000, 24'd10000000
   };

   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_NOT_RMC    = 3'd1,
      ST_FEW_FIELDS = 3'd2,
      ST_NOT_ACTIVE = 3'd3,
      ST_BAD_COORD  = 3'd4
   } status_type;

   typedef struct packed {
      status_type       status;
      logic             lat_neg;
      logic             lon_neg;
      logic [HDG_W-1:0] heading;
      logic             heading_ok;
   } side_type;

   typedef struct packed {
      side_type         side;
      logic [DEG_W-1:0] lat_deg;
      logic [MM_W-1:0]  lat_mm;
      logic [DEG_W-1:0] lon_deg;
      logic [MM_W-1:0]  lon_mm;
   } snap_type;

   typedef struct packed {
      logic ld2;
      logic ld3;
      logic ld4;
   } stage_en_type;

endpackage

// ===== rtl/nmea_rmc_position_parser.sv =====
// NMEA RMC position parser. Takes one received character per beat and, for each
// CR or LF that closes a sentence begun by '$', delivers one result beat with
// status, signed latitude/longitude in degrees*1e7 and course in centidegrees.
// A character is accepted every cycle unless the input stalls; a result passes
// through the line-end snapshot, three conversion stages for the minutes
// reciprocal multiply and correction, and the output register. The pipeline holds
// while the result side stalls, and input stalls only once every stage is full.
// Depends on nrmc_pkg, nrmc_parser, nrmc_coord_conv and the assertion macros.
`include "nmea_rmc_position_parser_macros.svh"

module nmea_rmc_position_parser
   import nrmc_pkg::*;
#(
   parameter int FRAC_DIGITS = 5
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [7:0]              req_rx_byte,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [2:0]              rsp_status_code,
   output logic signed [30:0]      rsp_latitude_e7,
   output logic signed [31:0]      rsp_longitude_e7,
   output logic [HDG_W-1:0]        rsp_heading_centideg,
   output logic                    rsp_heading_ok
);

   localparam int FRAC_W = $clog2(10**FRAC_DIGITS);
   localparam logic [MAG_W-1:0] LAT_MAX = 34'd900000000;
   localparam logic [MAG_W-1:0] LON_MAX = 34'd1800000000;

   logic              snap_valid;
   snap_type          snap;
   logic [FRAC_W-1:0] lat_frac, lon_frac;
   logic [MAG_W-1:0]  lat_mag, lon_mag;
   stage_en_type      en;

   logic     rdy1, rdy2, rdy3, rdy4, rdy_out;
   logic     v2_ff, v3_ff, v4_ff;
   side_type side2_ff, side3_ff, side4_ff;

   logic                   rsp_valid_ff;
   status_type             status_ff, status_in;
   logic signed [30:0]     lat_ff, lat_in;
   logic signed [31:0]     lon_ff, lon_in;
   logic [HDG_W-1:0]       hdg_ff, hdg_in;
   logic                   hok_ff, hok_in;
   logic [MAG_W-1:0]       lat_sgn, lon_sgn;

   assign rdy_out = !rsp_valid_ff || rsp_ready;
   assign rdy4    = !v4_ff || rdy_out;
   assign rdy3    = !v3_ff || rdy4;
   assign rdy2    = !v2_ff || rdy3;
   assign rdy1    = !snap_valid || rdy2;

   assign req_ready = rdy1;
   assign en.ld2    = rdy2;
   assign en.ld3    = rdy3;
   assign en.ld4    = rdy4;

   nrmc_parser #(.FRAC_DIGITS(FRAC_DIGITS)) u_parser (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_rx_byte (req_rx_byte),
      .advance     (rdy1),
      .snap_valid  (snap_valid),
      .snap        (snap),
      .lat_frac    (lat_frac),
      .lon_frac    (lon_frac)
   );

   nrmc_coord_conv #(.FRAC_DIGITS(FRAC_DIGITS)) u_lat_conv (
      .clock (clock),
      .en    (en),
      .deg   (snap.lat_deg),
      .mm    (snap.lat_mm),
      .frac  (lat_frac),
      .mag   (lat_mag)
   );

   nrmc_coord_conv #(.FRAC_DIGITS(FRAC_DIGITS)) u_lon_conv (
      .clock (clock),
      .en    (en),
      .deg   (snap.lon_deg),
      .mm    (snap.lon_mm),
      .frac  (lon_frac),
      .mag   (lon_mag)
   );

   assign lat_sgn = side4_ff.lat_neg ? (34'd0 - lat_mag) : lat_mag;
   assign lon_sgn = side4_ff.lon_neg ? (34'd0 - lon_mag) : lon_mag;

   always_comb begin
      status_in = side4_ff.status;
      if ((side4_ff.status == ST_OK) && ((lat_mag > LAT_MAX) || (lon_mag > LON_MAX))) begin
         status_in = ST_BAD_COORD;
      end
      lat_in = '0;
      lon_in = '0;
      hdg_in = '0;
      hok_in = 1'b0;
      if (status_in == ST_OK) begin
         lat_in = $signed(lat_sgn[30:0]);
         lon_in = $signed(lon_sgn[31:0]);
         hdg_in = side4_ff.heading;
         hok_in = side4_ff.heading_ok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rdy2) v2_ff <= snap_valid;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy_out) rsp_valid_ff <= v4_ff;
      end
      if (rdy2) side2_ff <= snap.side;
      if (rdy3) side3_ff <= side2_ff;
      if (rdy4) side4_ff <= side3_ff;
      if (rdy_out) begin
         status_ff <= status_in;
         lat_ff    <= lat_in;
         lon_ff    <= lon_in;
         hdg_ff    <= hdg_in;
         hok_ff    <= hok_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_status_code      = 3'(status_ff);
   assign rsp_latitude_e7      = lat_ff;
   assign rsp_longitude_e7     = lon_ff;
   assign rsp_heading_centideg = hdg_ff;
   assign rsp_heading_ok       = hok_ff;

   `NRMC_ASSERT_IMP(a_fail_zeroes, clock, reset,
      rsp_valid && (status_ff != ST_OK),
      (lat_ff == 31'sd0) && (lon_ff == 32'sd0) && !hok_ff && (hdg_ff == '0))
   `NRMC_ASSERT_IMP(a_heading_flag, clock, reset,
      rsp_valid && !hok_ff, hdg_ff == '0)
   `NRMC_ASSERT_IMP(a_lat_range, clock, reset,
      rsp_valid && (status_ff == ST_OK),
      (lat_ff >= -31'sd900000000) && (lat_ff <= 31'sd900000000))
   `NRMC_ASSERT_NXT(a_last_stage_holds, clock, reset,
      v4_ff && rsp_valid_ff && !rsp_ready, v4_ff)
   `NRMC_ASSERT_IMP(a_stall_only_full, clock, reset,
      !req_ready, snap_valid && v2_ff && v3_ff && v4_ff && rsp_valid_ff && !rsp_ready)

endmodule

// ===== rtl/nrmc_parser.sv =====
// Byte-level sentence parser: field split, talker/status/hemisphere checks and
// decimal accumulation; registers one snapshot per line end. Uses nrmc_pkg.
module nrmc_parser
   import nrmc_pkg::*;
#(
   parameter int FRAC_DIGITS = 5,
   localparam int FRAC_W = $clog2(10**FRAC_DIGITS)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [7:0]        req_rx_byte,
   input  logic              advance,
   output logic              snap_valid,
   output snap_type          snap,
   output logic [FRAC_W-1:0] lat_frac,
   output logic [FRAC_W-1:0] lon_frac
);

   localparam logic [7:0]  CH_DOLLAR = 8'h24;
   localparam logic [7:0]  CH_CR     = 8'h0D;
   localparam logic [7:0]  CH_LF     = 8'h0A;
   localparam logic [7:0]  CH_COMMA  = 8'h2C;
   localparam logic [7:0]  CH_POINT  = 8'h2E;
   localparam logic [7:0]  CH_ZERO   = 8'h30;
   localparam logic [7:0]  CH_NINE   = 8'h39;
   localparam logic [7:0]  CH_A      = 8'h41;
   localparam logic [7:0]  CH_S      = 8'h53;
   localparam logic [7:0]  CH_W      = 8'h57;
   localparam logic [23:0] TALKER_RMC = 24'h524D43;

   localparam logic [3:0] FLD_TALKER = 4'd0;
   localparam logic [3:0] FLD_STATUS = 4'd2;
   localparam logic [3:0] FLD_LAT    = 4'd3;
   localparam logic [3:0] FLD_NS     = 4'd4;
   localparam logic [3:0] FLD_LON    = 4'd5;
   localparam logic [3:0] FLD_EW     = 4'd6;
   localparam logic [3:0] FLD_COURSE = 4'd8;
   localparam logic [3:0] FLD_LAST   = 4'd15;
   localparam logic [3:0] FLD_MIN    = 4'd8;

   localparam logic [HDG_W-1:0] HDG_MAX = 17'd99999;

   typedef struct packed {
      logic over;
      logic bad;
      logic point;
      logic digit;
   } num_flags_type;

   typedef struct packed {
      num_flags_type     flags;
      logic [DEG_W-1:0]  deg;
      logic [MM_W-1:0]   mm;
      logic [FRAC_W-1:0] frac;
   } coord_type;

   typedef struct packed {
      num_flags_type    flags;
      logic [HDG_W-1:0] acc;
   } hdg_type;

   function automatic logic is_digit(logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   function automatic logic num_ok(num_flags_type f);
      return f.digit && !f.bad;
   endfunction

   function automatic coord_type coord_step(coord_type cur, logic [2:0] fc, logic [7:0] c);
      coord_type   nxt;
      logic [3:0]  d;
      logic [9:0]  t;
      logic [3:0]  tq;
      logic [2:0]  idx;
      logic [23:0] add;
      nxt = cur;
      d   = c[3:0];
      t   = 10'(cur.mm) * 10'd10 + 10'(d);
      tq  = 4'((16'(t) * 16'd41) >> 12);
      idx = 3'(FRAC_DIGITS - 1) - fc;
      add = 24'(d) * POW10[idx];
      if (is_digit(c)) begin
         nxt.flags.digit = 1'b1;
         if (cur.flags.point) begin
            if ((fc < 3'(FRAC_DIGITS)) && !cur.flags.over) begin
               nxt.frac = cur.frac + FRAC_W'(add);
            end
         end else if (!cur.flags.over) begin
            if (cur.deg >= 10'd100) begin
               nxt.flags.over = 1'b1;
            end else begin
               nxt.deg = 10'(cur.deg * 10'd10) + 10'(tq);
               nxt.mm  = 7'(t - 10'(tq) * 10'd100);
            end
         end
      end else if (c == CH_POINT) begin
         if (cur.flags.point) begin
            nxt.flags.bad = 1'b1;
         end else begin
            nxt.flags.point = 1'b1;
         end
      end else begin
         nxt.flags.bad = 1'b1;
      end
      return nxt;
   endfunction

   function automatic hdg_type hdg_step(hdg_type cur, logic [2:0] fc, logic [7:0] c);
      hdg_type    nxt;
      logic [3:0] d;
      nxt = cur;
      d   = c[3:0];
      if (is_digit(c)) begin
         nxt.flags.digit = 1'b1;
         if (cur.flags.point) begin
            if ((fc < 3'd2) && !cur.flags.over) begin
               nxt.acc = cur.acc + ((fc == 3'd0) ? 17'(d) * 17'd10 : 17'(d));
            end
         end else if (!cur.flags.over) begin
            if (cur.acc >= 17'd10000) begin
               nxt.flags.over = 1'b1;
            end else begin
               nxt.acc = cur.acc * 17'd10 + 17'(d) * 17'd100;
            end
         end
      end else if (c == CH_POINT) begin
         if (cur.flags.point) begin
            nxt.flags.bad = 1'b1;
         end else begin
            nxt.flags.point = 1'b1;
         end
      end else begin
         nxt.flags.bad = 1'b1;
      end
      return nxt;
   endfunction

   logic        in_sentence_ff, in_sentence_in;
   logic [3:0]  field_ff, field_in;
   logic [23:0] talker_ff, talker_in;
   logic        status_a_ff, status_a_in;
   logic        field_empty_ff, field_empty_in;
   coord_type   lat_ff, lat_in;
   coord_type   lon_ff, lon_in;
   hdg_type     hdg_ff, hdg_in;
   logic [2:0]  fc_ff, fc_in;
   logic        south_ff, south_in;
   logic        west_ff, west_in;
   logic        snap_valid_ff, snap_valid_in;
   snap_type    snap_ff, snap_in;
   logic [FRAC_W-1:0] lat_frac_ff, lon_frac_ff;

   logic       accept;
   logic [7:0] c;
   logic       eol;
   logic [2:0] fc_inc;

   assign accept = req_valid && advance;
   assign c      = req_rx_byte;
   assign eol    = (c == CH_CR) || (c == CH_LF);
   assign fc_inc = (fc_ff == 3'd7) ? fc_ff : fc_ff + 3'd1;

   always_comb begin
      in_sentence_in = in_sentence_ff;
      field_in       = field_ff;
      talker_in      = talker_ff;
      status_a_in    = status_a_ff;
      field_empty_in = field_empty_ff;
      lat_in         = lat_ff;
      lon_in         = lon_ff;
      hdg_in         = hdg_ff;
      fc_in          = fc_ff;
      south_in       = south_ff;
      west_in        = west_ff;
      if (accept) begin
         if (c == CH_DOLLAR) begin
            in_sentence_in = 1'b1;
            field_in       = '0;
            talker_in      = 24'(CH_DOLLAR);
            status_a_in    = 1'b0;
            field_empty_in = 1'b0;
            lat_in         = '0;
            lon_in         = '0;
            hdg_in         = '0;
            fc_in          = '0;
            south_in       = 1'b0;
            west_in        = 1'b0;
         end else if (in_sentence_ff) begin
            if (eol) begin
               in_sentence_in = 1'b0;
            end else if (c == CH_COMMA) begin
               field_in       = (field_ff == FLD_LAST) ? field_ff : field_ff + 4'd1;
               fc_in          = '0;
               field_empty_in = 1'b1;
            end else begin
               field_empty_in = 1'b0;
               unique case (field_ff)
                  FLD_TALKER: talker_in = {talker_ff[15:0], c};
                  FLD_STATUS: status_a_in = field_empty_ff && (c == CH_A);
                  FLD_LAT: begin
                     lat_in = coord_step(lat_ff, fc_ff, c);
                     if (is_digit(c) && lat_ff.flags.point) fc_in = fc_inc;
                  end
                  FLD_NS: south_in = field_empty_ff && (c == CH_S);
                  FLD_LON: begin
                     lon_in = coord_step(lon_ff, fc_ff, c);
                     if (is_digit(c) && lon_ff.flags.point) fc_in = fc_inc;
                  end
                  FLD_EW: west_in = field_empty_ff && (c == CH_W);
                  FLD_COURSE: begin
                     hdg_in = hdg_step(hdg_ff, fc_ff, c);
                     if (is_digit(c) && hdg_ff.flags.point) fc_in = fc_inc;
                  end
                  default: ;
               endcase
            end
         end
      end
   end

   always_comb begin
      snap_in = '0;
      priority if (talker_ff != TALKER_RMC) begin
         snap_in.side.status = ST_NOT_RMC;
      end else if (field_ff < FLD_MIN) begin
         snap_in.side.status = ST_FEW_FIELDS;
      end else if (!status_a_ff) begin
         snap_in.side.status = ST_NOT_ACTIVE;
      end else if (!num_ok(lat_ff.flags) || !num_ok(lon_ff.flags) ||
                   lat_ff.flags.over || lon_ff.flags.over) begin
         snap_in.side.status = ST_BAD_COORD;
      end else begin
         snap_in.side.status = ST_OK;
      end
      snap_in.side.lat_neg    = south_ff;
      snap_in.side.lon_neg    = west_ff;
      snap_in.side.heading_ok = num_ok(hdg_ff.flags);
      if (num_ok(hdg_ff.flags)) begin
         snap_in.side.heading = (hdg_ff.flags.over || (hdg_ff.acc > HDG_MAX)) ?
                                HDG_MAX : hdg_ff.acc;
      end
      snap_in.lat_deg = lat_ff.deg;
      snap_in.lat_mm  = lat_ff.mm;
      snap_in.lon_deg = lon_ff.deg;
      snap_in.lon_mm  = lon_ff.mm;
   end

   assign snap_valid_in = advance ? (accept && in_sentence_ff && eol && (c != CH_DOLLAR))
                                  : snap_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_sentence_ff <= 1'b0;
         snap_valid_ff  <= 1'b0;
      end else begin
         in_sentence_ff <= in_sentence_in;
         snap_valid_ff  <= snap_valid_in;
      end
      field_ff       <= field_in;
      talker_ff      <= talker_in;
      status_a_ff    <= status_a_in;
      field_empty_ff <= field_empty_in;
      lat_ff         <= lat_in;
      lon_ff         <= lon_in;
      hdg_ff         <= hdg_in;
      fc_ff          <= fc_in;
      south_ff       <= south_in;
      west_ff        <= west_in;
      if (advance) begin
         snap_ff     <= snap_in;
         lat_frac_ff <= lat_ff.frac;
         lon_frac_ff <= lon_ff.frac;
      end
   end

   assign snap_valid = snap_valid_ff;
   assign snap       = snap_ff;
   assign lat_frac   = lat_frac_ff;
   assign lon_frac   = lon_frac_ff;

endmodule

// ===== rtl/nrmc_coord_conv.sv =====
// Three-stage conversion of degrees, whole minutes and minute fraction into
// degrees times 1e7, minutes rounded by a reciprocal multiply. Uses nrmc_pkg.
module nrmc_coord_conv
   import nrmc_pkg::*;
#(
   parameter int FRAC_DIGITS = 5,
   localparam int FRAC_W = $clog2(10**FRAC_DIGITS)
) (
   input  logic              clock,
   input  stage_en_type      en,
   input  logic [DEG_W-1:0]  deg,
   input  logic [MM_W-1:0]   mm,
   input  logic [FRAC_W-1:0] frac,
   output logic [MAG_W-1:0]  mag
);

   localparam int unsigned FRAC_SCALE = 10**(7 - FRAC_DIGITS);
   localparam logic [28:0] RECIP15    = 29'h11111111;

   logic [29:0]      x;
   logic [27:0]      y2_ff, y2_in;
   logic [MAG_W-1:0] de2_ff, de2_in;
   logic [56:0]      prod;
   logic [23:0]      qe3_ff, qe3_in;
   logic [27:0]      y3_ff;
   logic [MAG_W-1:0] de3_ff;
   logic [27:0]      qe15;
   logic [27:0]      rem;
   logic [23:0]      q;
   logic [MAG_W-1:0] mag4_ff, mag4_in;

   assign x      = 30'(mm) * 30'd10000000 + 30'(frac) * 30'(FRAC_SCALE) + 30'd30;
   assign y2_in  = x[29:2];
   assign de2_in = 34'(deg) * E7;

   assign prod   = 57'(y2_ff) * 57'(RECIP15);
   assign qe3_in = prod[55:32];

   assign qe15    = {qe3_ff, 4'b0000} - {4'b0000, qe3_ff};
   assign rem     = y3_ff - qe15;
   assign q       = qe3_ff + 24'(rem >= 28'd15);
   assign mag4_in = de3_ff + 34'(q);

   always_ff @(posedge clock) begin
      if (en.ld2) begin
         y2_ff  <= y2_in;
         de2_ff <= de2_in;
      end
      if (en.ld3) begin
         qe3_ff <= qe3_in;
         y3_ff  <= y2_ff;
         de3_ff <= de2_ff;
      end
      if (en.ld4) begin
         mag4_ff <= mag4_in;
      end
   end

   assign mag = mag4_ff;

endmodule

// ===== sim/testbench.sv =====
// Self-checking bench for nmea_rmc_position_parser: a directed sentence table, then random
// RMC traffic with noise, under three handshake idling mixes and a long result hold-off.
// Uses nrmc_pkg and the parser RTL; expected fixes come from an in-bench model or the table.
module testbench;
   import nrmc_pkg::*;

   localparam int SCALE_DIGITS    = 5;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int SETTLE_CYCLES   = 16;
   localparam int RUN_LIMIT       = 2_000_000;

   localparam int FLD_TALKER = 0;
   localparam int FLD_STATUS = 2;
   localparam int FLD_LAT    = 3;
   localparam int FLD_NS     = 4;
   localparam int FLD_LON    = 5;
   localparam int FLD_EW     = 6;
   localparam int FLD_COURSE = 8;
   localparam int FLD_LAST   = 15;

   localparam int NUM_LAT = 0;
   localparam int NUM_LON = 4;
   localparam int NUM_HDG = 8;
   localparam logic [3:0] HAS_DIGIT = 4'd1;
   localparam logic [3:0] HAS_POINT = 4'd2;
   localparam logic [3:0] HAS_JUNK  = 4'd4;
   localparam logic [3:0] TOO_BIG   = 4'd8;

   localparam longint unsigned LAT_MAX_E7 = 64'd900000000;
   localparam longint unsigned LON_MAX_E7 = 64'd1800000000;
   localparam longint unsigned HDG_SAT    = 64'd99999;

   typedef struct packed {
      status_type              status;
      logic signed [30:0]      lat;
      logic signed [31:0]      lon;
      logic [HDG_W-1:0]        hdg;
      logic                    hdg_ok;
   } fix_type;

   typedef struct {
      string   text;
      bit      typed;
      fix_type fix;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [7:0] req_rx_byte = 8'd0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [2:0] rsp_status_code;
   logic signed [30:0] rsp_latitude_e7;
   logic signed [31:0] rsp_longitude_e7;
   logic [HDG_W-1:0] rsp_heading_centideg;
   logic rsp_heading_ok;

   nmea_rmc_position_parser #(.FRAC_DIGITS(SCALE_DIGITS)) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status_code(rsp_status_code),
      .rsp_latitude_e7(rsp_latitude_e7),
      .rsp_longitude_e7(rsp_longitude_e7),
      .rsp_heading_centideg(rsp_heading_centideg),
      .rsp_heading_ok(rsp_heading_ok)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // sentence model state
   bit              in_msg;
   logic [3:0]      field_idx;
   logic [23:0]     head_tail;
   bit              mode_active;
   longint unsigned lat_value;
   longint unsigned lon_value;
   longint unsigned course_value;
   logic [11:0]     num_flags;
   logic [2:0]      frac_seen;
   logic [1:0]      hemi_neg;
   logic [1:0]      field_len;

   fix_type pending_fixes[$];
   row_type dir_rows[$];
   bit      typed_pending;
   fix_type typed_fix;
   int      req_idle_pct;
   int      rsp_idle_pct;
   int      hold_offs_asked;
   int      hold_offs_served;
   int      busy_bytes;
   int      fixes_predicted;
   int      fixes_checked;
   int      errors;

   function automatic longint unsigned ten_to(int n);
      longint unsigned p = 1;
      for (int i = 0; i < n; i++) p = p * 10;
      return p;
   endfunction

   function automatic void clear_msg();
      field_idx = '0;
      head_tail = '0;
      mode_active = 1'b0;
      lat_value = 0;
      lon_value = 0;
      course_value = 0;
      num_flags = '0;
      frac_seen = '0;
      hemi_neg = '0;
      field_len = '0;
   endfunction

   function automatic void add_numeric(int grp, int fd, byte unsigned c);
      logic [3:0] g;
      longint unsigned acc;
      longint unsigned scale;
      longint unsigned limit;
      g = num_flags[grp +: 4];
      case (grp)
         NUM_LAT: acc = lat_value;
         NUM_LON: acc = lon_value;
         default: acc = course_value;
      endcase
      scale = ten_to(fd);
      if (c >= "0" && c <= "9") begin
         g |= HAS_DIGIT;
         if ((g & HAS_POINT) != 0) begin
            if (frac_seen < fd && (g & TOO_BIG) == 0)
               acc += longint'(c - "0") * ten_to(fd - 1 - frac_seen);
            if (frac_seen < 7) frac_seen++;
         end else if ((g & TOO_BIG) == 0) begin
            limit = (grp == NUM_HDG ? 100 : 10000) * scale;
            if (acc >= limit) g |= TOO_BIG;
            else acc = acc * 10 + longint'(c - "0") * scale;
         end
      end else if (c == ".") begin
         if ((g & HAS_POINT) != 0) g |= HAS_JUNK;
         else g |= HAS_POINT;
      end else begin
         g |= HAS_JUNK;
      end
      num_flags[grp +: 4] = g;
      case (grp)
         NUM_LAT: lat_value = acc;
         NUM_LON: lon_value = acc;
         default: course_value = acc;
      endcase
   endfunction

   function automatic bit number_good(int grp);
      logic [3:0] g;
      g = num_flags[grp +: 4];
      return (g & HAS_DIGIT) != 0 && (g & HAS_JUNK) == 0;
   endfunction

   function automatic longint unsigned degrees_e7(longint unsigned v);
      longint unsigned s;
      longint unsigned deg;
      longint unsigned mins;
      s = ten_to(SCALE_DIGITS);
      deg = v / (100 * s);
      mins = v - deg * 100 * s;
      return deg * 64'd10000000 + (mins * 64'd10000000 + 30 * s) / (60 * s);
   endfunction

   function automatic bit parse_rx_byte(byte unsigned c, output fix_type fix);
      status_type st;
      longint unsigned lat_mag;
      longint unsigned lon_mag;
      fix = '0;
      if (c == "$") begin
         clear_msg();
         in_msg = 1'b1;
         head_tail = 24'(c);
         field_len = 2'd1;
         return 1'b0;
      end
      if (!in_msg) return 1'b0;
      if (c == 8'h0D || c == 8'h0A) begin
         in_msg = 1'b0;
         st = ST_OK;
         lat_mag = 0;
         lon_mag = 0;
         if (head_tail != "RMC") st = ST_NOT_RMC;
         else if (field_idx < FLD_COURSE) st = ST_FEW_FIELDS;
         else if (!mode_active) st = ST_NOT_ACTIVE;
         else if (!number_good(NUM_LAT) || !number_good(NUM_LON) ||
                  num_flags[NUM_LAT + 3] || num_flags[NUM_LON + 3]) st = ST_BAD_COORD;
         else begin
            lat_mag = degrees_e7(lat_value);
            lon_mag = degrees_e7(lon_value);
            if (lat_mag > LAT_MAX_E7 || lon_mag > LON_MAX_E7) st = ST_BAD_COORD;
         end
         fix.status = st;
         if (st == ST_OK) begin
            if (number_good(NUM_HDG)) begin
               fix.hdg_ok = 1'b1;
               if (num_flags[NUM_HDG + 3] || course_value > HDG_SAT) fix.hdg = HDG_SAT[16:0];
               else fix.hdg = course_value[16:0];
            end
            fix.lat = hemi_neg[0] ? -lat_mag[30:0] : lat_mag[30:0];
            fix.lon = hemi_neg[1] ? -lon_mag[31:0] : lon_mag[31:0];
         end
         return 1'b1;
      end
      if (c == ",") begin
         if (field_idx < FLD_LAST) field_idx++;
         frac_seen = '0;
         field_len = '0;
         return 1'b0;
      end
      case (field_idx)
         FLD_TALKER: head_tail = {head_tail[15:0], c};
         FLD_STATUS: mode_active = (field_len == 0 && c == "A");
         FLD_LAT:    add_numeric(NUM_LAT, SCALE_DIGITS, c);
         FLD_NS:     hemi_neg[0] = (field_len == 0 && c == "S");
         FLD_LON:    add_numeric(NUM_LON, SCALE_DIGITS, c);
         FLD_EW:     hemi_neg[1] = (field_len == 0 && c == "W");
         FLD_COURSE: add_numeric(NUM_HDG, 2, c);
         default: ;
      endcase
      if (field_len < 2) field_len++;
      return 1'b0;
   endfunction

   function automatic fix_type make_fix(status_type st, longint lat, longint lon, int hdg,
                                        bit ok);
      fix_type f;
      f.status = st;
      f.lat = 31'(lat);
      f.lon = 32'(lon);
      f.hdg = 17'(hdg);
      f.hdg_ok = ok;
      return f;
   endfunction

   task automatic add_row(string text, bit typed = 1'b0, fix_type fix = '0);
      row_type r;
      r.text = text;
      r.typed = typed;
      r.fix = fix;
      dir_rows.push_back(r);
   endtask

   task automatic send_byte(byte unsigned b);
      fix_type fix;
      req_valid <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      if (in_msg || b == "$") busy_bytes++;
      if (parse_rx_byte(b, fix)) begin
         if (typed_pending) begin
            fix = typed_fix;
            typed_pending = 1'b0;
         end
         pending_fixes.push_back(fix);
         fixes_predicted++;
      end
      if ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < req_idle_pct);
      end
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_fixes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic string digits(int n);
      string t = "";
      for (int i = 0; i < n; i++) t = {t, $sformatf("%0d", $urandom_range(0, 9))};
      return t;
   endfunction

   function automatic string coord_text(bit is_lon);
      string t;
      int pick;
      pick = $urandom_range(19);
      if (pick == 0) t = digits($urandom_range(0, 7));
      else if (is_lon) t = $sformatf("%03d%02d", $urandom_range(0, 180), $urandom_range(0, 59));
      else t = $sformatf("%02d%02d", $urandom_range(0, 90), $urandom_range(0, 59));
      if (pick != 1) t = {t, ".", digits($urandom_range(0, 7))};
      return t;
   endfunction

   task automatic send_random_sentence();
      string s;
      int pos;
      if ($urandom_range(99) < 8) begin
         repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(0, 255)));
         return;
      end
      case ($urandom_range(9))
         0: s = "$GPGGA";
         1: s = $sformatf("$%c%c%c", $urandom_range(65, 90), $urandom_range(65, 90),
                          $urandom_range(65, 90));
         2: s = "$RM";
         default: s = $urandom_range(1) ? "$GPRMC" : "$GNRMC";
      endcase
      s = {s, ",", digits($urandom_range(0, 6)), ","};
      case ($urandom_range(11))
         0: s = {s, "V"};
         1: s = {s, ""};
         2: s = {s, "AA"};
         default: s = {s, "A"};
      endcase
      s = {s, ",", coord_text(1'b0), ",", ($urandom_range(9) == 0) ? "SS" :
           ($urandom_range(1) ? "S" : "N")};
      s = {s, ",", coord_text(1'b1), ",", ($urandom_range(9) == 0) ? "" :
           ($urandom_range(1) ? "W" : "E")};
      if ($urandom_range(19) != 0) s = {s, ",", digits($urandom_range(0, 3)), ","};
      case ($urandom_range(7))
         0: s = {s, ""};
         1: s = {s, digits($urandom_range(1, 2)), "x"};
         2: s = {s, digits($urandom_range(0, 5))};
         default: s = {s, digits($urandom_range(0, 4)), ".", digits($urandom_range(0, 4))};
      endcase
      repeat ($urandom_range(0, 10)) s = {s, ",", digits($urandom_range(0, 3))};
      if ($urandom_range(1)) s = {s, $sformatf("*%02X", $urandom_range(0, 255))};
      if ($urandom_range(19) == 0) begin
         pos = $urandom_range(1, s.len() - 1);
         s[pos] = 8'($urandom_range(1, 255));
      end
      if ($urandom_range(15) == 0) begin
         s = s.substr(0, $urandom_range(0, s.len() - 1));
      end else begin
         case ($urandom_range(2))
            0: s = {s, "\r\n"};
            1: s = {s, "\r"};
            default: s = {s, "\n"};
         endcase
      end
      send_text(s);
   endtask

   task automatic run_random(int min_bytes, int min_fixes);
      int bytes_at_start;
      int fixes_at_start;
      bytes_at_start = busy_bytes;
      fixes_at_start = fixes_predicted;
      while (busy_bytes - bytes_at_start < min_bytes ||
             fixes_predicted - fixes_at_start < min_fixes)
         send_random_sentence();
   endtask

   task automatic check_field(string name, logic signed [63:0] want, logic signed [63:0] got);
      if (got !== want) begin
         $error("%s expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      fix_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_fixes.size() == 0) begin
            $error("result beat with nothing expected, status_code %0d", rsp_status_code);
            errors++;
         end else begin
            want = pending_fixes.pop_front();
            fixes_checked++;
            check_field("status_code", want.status, rsp_status_code);
            check_field("latitude_e7", want.lat, rsp_latitude_e7);
            check_field("longitude_e7", want.lon, rsp_longitude_e7);
            check_field("heading_centideg", want.hdg, rsp_heading_centideg);
            check_field("heading_ok", want.hdg_ok, rsp_heading_ok);
         end
      end
   end

   initial begin
      forever begin
         @(posedge clock);
         if (hold_offs_served != hold_offs_asked) begin
            hold_offs_served++;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   initial begin
      #(RUN_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      in_msg = 1'b0;
      clear_msg();
      req_idle_pct = 34;
      rsp_idle_pct = 59;

      add_row("junk outside,\r\n");
      add_row("$\r", 1'b1, make_fix(ST_NOT_RMC, 0, 0, 0, 1'b0));
      add_row("$GPRMC,000000,A,0000.00000,N,00000.00000,E,0.0,0.00,010100,,\r\n",
              1'b1, make_fix(ST_OK, 0, 0, 0, 1'b1));
      add_row("$GPRMC,235959,A,9000.00000,S,18000.00000,W,999.9,999.99,311299,,*6C\r\n",
              1'b1, make_fix(ST_OK, -900000000, -1800000000, 99999, 1'b1));
      add_row("$GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W*6A\r\n");
      add_row("$GNRMC,1,A,3345.1234567,S,15112.9876543,W,1.0,359.99,,,\n");
      add_row("$GPGGA,1,A,4807.038,N,01131.000,E,,,\r",
              1'b1, make_fix(ST_NOT_RMC, 0, 0, 0, 1'b0));
      add_row("$GPRMC,1,A,4807.038,N,01131.000,E,0.5\r",
              1'b1, make_fix(ST_FEW_FIELDS, 0, 0, 0, 1'b0));
      add_row("$GPRMC,1,A,4807.038,N,01131.000,E,0.5,\r");
      add_row("$GPRMC,1,V,4807.038,N,01131.000,E,,,\r",
              1'b1, make_fix(ST_NOT_ACTIVE, 0, 0, 0, 1'b0));
      add_row("$GPRMC,1,AA,4807.038,N,01131.000,E,,,\r",
              1'b1, make_fix(ST_NOT_ACTIVE, 0, 0, 0, 1'b0));
      add_row("$GPRMC,1,,4807.038,N,01131.000,E,,,\r",
              1'b1, make_fix(ST_NOT_ACTIVE, 0, 0, 0, 1'b0));
      add_row("$GPRMC,1,A,,N,01131.000,E,,,\r", 1'b1, make_fix(ST_BAD_COORD, 0, 0, 0, 1'b0));
      add_row("$GPRMC,1,A,48.07.038,N,01131.000,E,,,\r",
              1'b1, make_fix(ST_BAD_COORD, 0, 0, 0, 1'b0));
      add_row("$GPRMC,1,A,4807.038,N,011*1.000,E,,,\r",
              1'b1, make_fix(ST_BAD_COORD, 0, 0, 0, 1'b0));
      add_row("$GPRMC,1,A,123456.0,N,01131.000,E,,,\r",
              1'b1, make_fix(ST_BAD_COORD, 0, 0, 0, 1'b0));
      add_row("$GPRMC,1,A,9000.00001,N,00000.0,E,,,\r",
              1'b1, make_fix(ST_BAD_COORD, 0, 0, 0, 1'b0));
      add_row("$GPRMC,1,A,0000.0,N,18100.0,E,,,\r",
              1'b1, make_fix(ST_BAD_COORD, 0, 0, 0, 1'b0));
      add_row("$GPRMC,1,A,0000.0,SS,00000.0,WW,,1234.5,\r",
              1'b1, make_fix(ST_OK, 0, 0, 99999, 1'b1));
      add_row("$GPRMC,1,A,0000.0,N,00000.0,E,,12.3456,\r",
              1'b1, make_fix(ST_OK, 0, 0, 1234, 1'b1));
      add_row("$GPRMC,1,A,0000.0,N,00000.0,E,,1x,\r", 1'b1, make_fix(ST_OK, 0, 0, 0, 1'b0));
      add_row("$GPRMC,1,A,0000.0,N,00000.0,E,,.,\r", 1'b1, make_fix(ST_OK, 0, 0, 0, 1'b0));
      add_row("$GPRMC,1,A,45$GPRMC,2,A,0100.5,S,00030.25,W,,7.5,1,2,3,4,5,6,7,8,9,10\377,11\r\n");
      add_row("$XYRMCRMC,1,A,4500.0,N,09000.0,E,,90,,\n");
      add_row("$GPRMC,1,A,0030.00005,N,00000.00003,E,,,\r");

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_byte(8'h00);
      send_byte(8'hFF);
      foreach (dir_rows[i]) begin
         typed_pending = dir_rows[i].typed;
         typed_fix = dir_rows[i].fix;
         send_text(dir_rows[i].text);
      end
      run_random(550, 20);
      wait_for_results();

      req_idle_pct = 59;
      rsp_idle_pct = 34;
      run_random(550, 20);
      wait_for_results();

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_offs_asked++;
      repeat (60) send_text($urandom_range(1) ? "$\n" : "$GPRMC,1,A,0000.1,N,00000.1,E,,,\r");
      wait_for_results();
      run_random(550, 20);
      wait_for_results();

      $display("Checked %0d results from %0d in-sentence bytes over three idling mixes,",
               fixes_checked, busy_bytes);
      $display("with a long result hold-off that backed up the byte input.");
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end
endmodule

// ===== nmea_rmc_position_parser.f =====
+incdir+rtl
rtl/nrmc_pkg.sv
rtl/nrmc_parser.sv
rtl/nrmc_coord_conv.sv
rtl/nmea_rmc_position_parser.sv
sim/testbench.sv
